// ===== src/tbpc_pkg.sv =====
package tbpc_pkg;

    localparam int COUNT_WIDTH_DEFAULT = 16;
    localparam int THRESH_WIDTH        = 16;
    localparam int EVENT_WIDTH         = 3;
    localparam int NUM_EVENTS          = 6;
    localparam int CFG_INDEX_WIDTH     = 2;
    localparam int CFG_DATA_WIDTH      = 16;

    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SHORT_THRESHOLD = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_LONG_THRESHOLD  = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_EVENT_ENABLE    = 2'd2;

    localparam logic [THRESH_WIDTH-1:0] SHORT_THRESHOLD_RESET = 16'd60;
    localparam logic [THRESH_WIDTH-1:0] LONG_THRESHOLD_RESET  = 16'd180;
    localparam logic [NUM_EVENTS-1:0]   EVENT_ENABLE_RESET    = 6'd0;

    localparam logic [EVENT_WIDTH-1:0] EV_BOTH_LONG  = 3'd0;
    localparam logic [EVENT_WIDTH-1:0] EV_BOTH_SHORT = 3'd1;
    localparam logic [EVENT_WIDTH-1:0] EV_ONE_LONG   = 3'd2;
    localparam logic [EVENT_WIDTH-1:0] EV_ONE_SHORT  = 3'd3;
    localparam logic [EVENT_WIDTH-1:0] EV_TWO_LONG   = 3'd4;
    localparam logic [EVENT_WIDTH-1:0] EV_TWO_SHORT  = 3'd5;

    typedef enum logic [1:0] {
        COMBO_IDLE = 2'd0,
        COMBO_BOTH = 2'd1,
        COMBO_ONE  = 2'd2,
        COMBO_TWO  = 2'd3
    } combo_t;

    typedef struct packed {
        logic [THRESH_WIDTH-1:0] short_threshold;
        logic [THRESH_WIDTH-1:0] long_threshold;
        logic [NUM_EVENTS-1:0]   event_enable;
    } tbpc_cfg_t;

    typedef struct packed {
        logic valid;
        logic button1;
        logic button2;
    } tbpc_tick_t;

    typedef struct packed {
        logic                   emit;
        logic [EVENT_WIDTH-1:0] code;
    } tbpc_result_t;

    function automatic logic [EVENT_WIDTH-1:0] event_code(input combo_t combo,
                                                          input logic   is_short);
        logic [EVENT_WIDTH-1:0] code;
        case (combo)
            COMBO_BOTH: code = is_short ? EV_BOTH_SHORT : EV_BOTH_LONG;
            COMBO_ONE:  code = is_short ? EV_ONE_SHORT  : EV_ONE_LONG;
            COMBO_TWO:  code = is_short ? EV_TWO_SHORT  : EV_TWO_LONG;
            default:    code = EV_BOTH_LONG;
        endcase
        return code;
    endfunction

endpackage

// ===== src/tbpc_cfg_regs.sv =====
module tbpc_cfg_regs
    import tbpc_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_valid,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]  cfg_data,
    output tbpc_cfg_t                  cfg
);

    tbpc_cfg_t cfg_reg;
    tbpc_cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                CFG_SHORT_THRESHOLD: cfg_next.short_threshold = cfg_data;
                CFG_LONG_THRESHOLD:  cfg_next.long_threshold  = cfg_data;
                CFG_EVENT_ENABLE:    cfg_next.event_enable    = cfg_data[NUM_EVENTS-1:0];
                default:             cfg_next = cfg_reg;  // unmapped index, dropped
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.short_threshold <= SHORT_THRESHOLD_RESET;
            cfg_reg.long_threshold  <= LONG_THRESHOLD_RESET;
            cfg_reg.event_enable    <= EVENT_ENABLE_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== src/tbpc_in_stage.sv =====
module tbpc_in_stage
    import tbpc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_button1_pressed,
    input  logic       s_button2_pressed,
    input  logic       advance,
    output tbpc_tick_t tick
);

    logic valid_reg, valid_next;
    logic b1_reg, b1_next;
    logic b2_reg, b2_next;

    assign s_ready = !valid_reg || advance;

    always_comb begin
        valid_next = valid_reg;
        b1_next    = b1_reg;
        b2_next    = b2_reg;
        if (s_ready) begin
            valid_next = s_valid;
            if (s_valid) begin
                b1_next = s_button1_pressed;
                b2_next = s_button2_pressed;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        b1_reg <= b1_next;
        b2_reg <= b2_next;
    end

    assign tick.valid   = valid_reg;
    assign tick.button1 = b1_reg;
    assign tick.button2 = b2_reg;

endmodule

// ===== src/tbpc_classify.sv =====
module tbpc_classify
    import tbpc_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         step,
    input  tbpc_tick_t   tick,
    input  tbpc_cfg_t    cfg,
    output tbpc_result_t result
);

    localparam int CMP_W = (COUNT_WIDTH > THRESH_WIDTH) ? COUNT_WIDTH : THRESH_WIDTH;

    combo_t                 armed_reg, armed_next;
    logic [COUNT_WIDTH-1:0] count_reg, count_next;
    logic [COUNT_WIDTH-1:0] count_inc;
    logic [CMP_W-1:0]       count_cmp;
    logic [CMP_W-1:0]       short_cmp;
    logic [CMP_W-1:0]       long_cmp;
    combo_t                 held;
    logic                   hit;
    logic                   is_short;
    logic [EVENT_WIDTH-1:0] code;

    always_comb begin
        // saturating increment comes first every tick
        count_inc = (count_reg == {COUNT_WIDTH{1'b1}}) ? count_reg
                                                       : count_reg + 1'b1;
        count_cmp = CMP_W'(count_inc);
        short_cmp = CMP_W'(cfg.short_threshold);
        long_cmp  = CMP_W'(cfg.long_threshold);

        case ({tick.button1, tick.button2})
            2'b11:   held = COMBO_BOTH;
            2'b10:   held = COMBO_ONE;
            2'b01:   held = COMBO_TWO;
            default: held = COMBO_IDLE;
        endcase

        count_next = count_inc;
        armed_next = armed_reg;
        hit        = 1'b0;
        is_short   = 1'b0;

        if (armed_reg == COMBO_IDLE) begin
            if (held == COMBO_IDLE) begin
                count_next = '0;
            end else if (count_cmp >= short_cmp) begin
                armed_next = held;
            end
        end else begin
            if (held == armed_reg && count_cmp >= long_cmp) begin
                hit = 1'b1;
            end else if (held == COMBO_IDLE && count_cmp < long_cmp) begin
                hit      = 1'b1;
                is_short = 1'b1;
            end
            if (hit) begin
                armed_next = COMBO_IDLE;
                count_next = '0;
            end
        end

        code        = event_code(armed_reg, is_short);
        result.code = code;
        result.emit = hit && cfg.event_enable[code];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            armed_reg <= COMBO_IDLE;
            count_reg <= '0;
        end else if (step) begin
            armed_reg <= armed_next;
            count_reg <= count_next;
        end
    end

endmodule

// ===== src/two_button_press_classifier_top.sv =====
// Path: a tick beat's event reaches m_* through the tick register, then the
//   event register; it is held back while m_ready holds a pending beat.
// Throughput: one tick beat per cycle unless m_ready stalls a pending event;
//   input register, classifier state and event register advance together.
// Reset: aresetn is synchronous, active low; clears combo state, tick counter,
//   beat valids, and loads thresholds 60/180 with all events disabled.
module two_button_press_classifier_top
    import tbpc_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    // tick channel
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic                       s_button1_pressed,
    input  logic                       s_button2_pressed,
    // event channel
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [EVENT_WIDTH-1:0]     m_press_event,
    // register writes
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]  cfg_data
);

    tbpc_cfg_t    cfg;
    tbpc_tick_t   tick;
    tbpc_result_t result;
    logic         advance;

    logic                   out_valid_reg, out_valid_next;
    logic [EVENT_WIDTH-1:0] out_event_reg, out_event_next;

    // register writes never stall
    assign cfg_ready = 1'b1;

    tbpc_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // The registered tick moves on when the event register is free or is
    // being drained this cycle; a tick with no event still needs the slot
    // check so ordering is kept simple.
    assign advance = tick.valid && (!out_valid_reg || m_ready);

    tbpc_in_stage u_in (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_button1_pressed (s_button1_pressed),
        .s_button2_pressed (s_button2_pressed),
        .advance           (advance),
        .tick              (tick)
    );

    tbpc_classify #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_classify (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .tick    (tick),
        .cfg     (cfg),
        .result  (result)
    );

    // event register: holds one beat until the sink takes it
    always_comb begin
        out_valid_next = out_valid_reg;
        out_event_next = out_event_reg;
        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end
        if (advance && result.emit) begin
            out_valid_next = 1'b1;
            out_event_next = result.code;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_event_reg <= out_event_next;
    end

    assign m_valid       = out_valid_reg;
    assign m_press_event = out_event_reg;

`ifndef SYNTH
    // empty event register means the tick path can never be blocked
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("tick input stalled with empty event register");

    // only defined event codes leave the block
    a_code_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_press_event <= EV_TWO_SHORT))
        else $error("undefined event code on output");

    // every delivered beat carries an enabled event
    a_code_enabled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (((cfg.event_enable >> m_press_event) & 6'd1) != 6'd0))
        else $error("disabled event reached the output");

    // a beat pending on a stalled sink is not overwritten by a new event
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !advance)
        else $error("classifier advanced over a pending event");
`endif

endmodule
